[rtl/bvcp_pkg.sv]
// ----------------------------------------------------------------------------
// bvcp_pkg: shared types and constants of the battery charge percent unit
// Microcode opcodes, jump conditions, control word layout, status from the
// datapath and the rest-voltage curve of one LiPo cell.
// ----------------------------------------------------------------------------
package bvcp_pkg;

    // Field widths
    localparam int PIN_W  = 12;
    localparam int OHM_W  = 24;
    localparam int PACK_W = 16;
    localparam int PCT_W  = 7;
    localparam int PROD_W = PIN_W + OHM_W;
    localparam int CELL_W = 13;
    localparam int CNT_W  = 5;
    localparam int PC_W   = 4;
    localparam int SEG_W  = 4;

    // Configuration register index
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_OHMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OHMS  = 1'b1;

    // Cells in series in the pack
    localparam int CELL_COUNT = 2;

    // Quotient bits produced per division pass
    localparam logic [CNT_W-1:0] DIV_BITS = 5'd16;

    localparam logic [PACK_W-1:0] PACK_MAX  = 16'hFFFF;
    localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_STEP  = 7'd10;
    localparam logic [3:0]        OCV_LAST  = 4'd10;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_LD_SCALE,
        OP_DIV_STEP,
        OP_STORE_PACK,
        OP_LD_CELL,
        OP_SEG,
        OP_LD_FRAC,
        OP_SET_PCT,
        OP_PUBLISH
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_NOT_OK,
        C_LOOP_MORE,
        C_NO_READING,
        C_CLAMP,
        C_OUT_BUSY
    } t_cond;

    // One microcode control word
    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Status returned by the datapath
    typedef struct packed {
        logic sample_ok;
        logic have_reading;
        logic cnt_last;
        logic clamp;
    } t_dp_stat;

    // Rest voltage of one cell at 0%, 10%, ... 100% charge
    function automatic logic [CELL_W-1:0] ocv_point(input logic [3:0] k);
        logic [CELL_W-1:0] mv;
        case (k)
            4'd0:    mv = 13'd3450;
            4'd1:    mv = 13'd3680;
            4'd2:    mv = 13'd3740;
            4'd3:    mv = 13'd3770;
            4'd4:    mv = 13'd3790;
            4'd5:    mv = 13'd3820;
            4'd6:    mv = 13'd3870;
            4'd7:    mv = 13'd3920;
            4'd8:    mv = 13'd3980;
            4'd9:    mv = 13'd4060;
            default: mv = 13'd4200;
        endcase
        return mv;
    endfunction

endpackage

[rtl/bvcp_useq.sv]
// ----------------------------------------------------------------------------
// bvcp_useq: microcode sequencer
// Step counter, control store and jump logic. One control word per step.
// ----------------------------------------------------------------------------
module bvcp_useq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_out_busy,
    input  bvcp_pkg::t_dp_stat        i_stat,
    output bvcp_pkg::t_op             o_op,
    output logic                      o_idle
);

    // Program labels
    localparam logic [bvcp_pkg::PC_W-1:0] L_IDLE   = 4'd0;
    localparam logic [bvcp_pkg::PC_W-1:0] L_MUL    = 4'd1;
    localparam logic [bvcp_pkg::PC_W-1:0] L_LDSC   = 4'd2;
    localparam logic [bvcp_pkg::PC_W-1:0] L_DIVSC  = 4'd3;
    localparam logic [bvcp_pkg::PC_W-1:0] L_STORE  = 4'd4;
    localparam logic [bvcp_pkg::PC_W-1:0] L_PCT    = 4'd5;
    localparam logic [bvcp_pkg::PC_W-1:0] L_SEG    = 4'd6;
    localparam logic [bvcp_pkg::PC_W-1:0] L_LDFR   = 4'd7;
    localparam logic [bvcp_pkg::PC_W-1:0] L_DIVFR  = 4'd8;
    localparam logic [bvcp_pkg::PC_W-1:0] L_SETPCT = 4'd9;
    localparam logic [bvcp_pkg::PC_W-1:0] L_PUB    = 4'd10;
    localparam logic [bvcp_pkg::PC_W-1:0] L_DONE   = 4'd11;

    // Control store
    function automatic bvcp_pkg::t_uword ucode(input logic [bvcp_pkg::PC_W-1:0] pc);
        bvcp_pkg::t_uword w;
        unique case (pc)
            L_IDLE:   w = '{bvcp_pkg::OP_NOP,        bvcp_pkg::C_NO_START,   L_IDLE};
            L_MUL:    w = '{bvcp_pkg::OP_MUL,        bvcp_pkg::C_NOT_OK,     L_PCT};
            L_LDSC:   w = '{bvcp_pkg::OP_LD_SCALE,   bvcp_pkg::C_NEVER,      L_IDLE};
            L_DIVSC:  w = '{bvcp_pkg::OP_DIV_STEP,   bvcp_pkg::C_LOOP_MORE,  L_DIVSC};
            L_STORE:  w = '{bvcp_pkg::OP_STORE_PACK, bvcp_pkg::C_NEVER,      L_IDLE};
            L_PCT:    w = '{bvcp_pkg::OP_LD_CELL,    bvcp_pkg::C_NO_READING, L_PUB};
            L_SEG:    w = '{bvcp_pkg::OP_SEG,        bvcp_pkg::C_CLAMP,      L_PUB};
            L_LDFR:   w = '{bvcp_pkg::OP_LD_FRAC,    bvcp_pkg::C_NEVER,      L_IDLE};
            L_DIVFR:  w = '{bvcp_pkg::OP_DIV_STEP,   bvcp_pkg::C_LOOP_MORE,  L_DIVFR};
            L_SETPCT: w = '{bvcp_pkg::OP_SET_PCT,    bvcp_pkg::C_NEVER,      L_IDLE};
            L_PUB:    w = '{bvcp_pkg::OP_PUBLISH,    bvcp_pkg::C_OUT_BUSY,   L_PUB};
            L_DONE:   w = '{bvcp_pkg::OP_NOP,        bvcp_pkg::C_ALWAYS,     L_IDLE};
            default:  w = '{bvcp_pkg::OP_NOP,        bvcp_pkg::C_ALWAYS,     L_IDLE};
        endcase
        return w;
    endfunction

    logic [bvcp_pkg::PC_W-1:0] r_pc;
    logic [bvcp_pkg::PC_W-1:0] n_pc;
    bvcp_pkg::t_uword          w_word;
    logic                      w_take;

    assign w_word = ucode(r_pc);

    // Evaluate the jump condition of the current step
    always_comb begin
        unique case (w_word.cond)
            bvcp_pkg::C_NEVER:      w_take = 1'b0;
            bvcp_pkg::C_ALWAYS:     w_take = 1'b1;
            bvcp_pkg::C_NO_START:   w_take = !i_start;
            bvcp_pkg::C_NOT_OK:     w_take = !i_stat.sample_ok;
            bvcp_pkg::C_LOOP_MORE:  w_take = !i_stat.cnt_last;
            bvcp_pkg::C_NO_READING: w_take = !i_stat.have_reading;
            bvcp_pkg::C_CLAMP:      w_take = i_stat.clamp;
            bvcp_pkg::C_OUT_BUSY:   w_take = i_out_busy;
            default:                w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : r_pc + 4'd1;
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op   = w_word.op;
    assign o_idle = (r_pc == L_IDLE);

endmodule

[rtl/bvcp_dpath.sv]
// ----------------------------------------------------------------------------
// bvcp_dpath: datapath of the battery charge percent unit
// Input capture, divider multiply, shared restoring divider (one quotient bit
// per step), reciprocal multiply for the per-cell voltage, table segment
// search and the stored pack state.
// ----------------------------------------------------------------------------
module bvcp_dpath #(
    parameter int CELL_COUNT = bvcp_pkg::CELL_COUNT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [bvcp_pkg::PIN_W-1:0]          i_pin_millivolts,
    input  logic                                i_sample_ok,
    input  logic [bvcp_pkg::OHM_W-1:0]          i_full_ohms,
    input  logic [bvcp_pkg::OHM_W-1:0]          i_out_ohms,
    input  bvcp_pkg::t_op                       i_op,
    output bvcp_pkg::t_dp_stat                  o_stat,
    output logic [bvcp_pkg::PACK_W-1:0]         o_pack_millivolts,
    output logic [bvcp_pkg::PCT_W-1:0]          o_charge_percent,
    output logic                                o_reading_present
);

    // Reciprocal of the cell count, exact for every 16-bit pack voltage
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int CPROD_W     = bvcp_pkg::PACK_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CELL_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + CELL_COUNT - 1) / CELL_COUNT);

    // Captured transaction
    logic [bvcp_pkg::PIN_W-1:0]  r_pin;
    logic                        r_ok;

    // Arithmetic registers
    logic [bvcp_pkg::PROD_W-1:0] r_prod;
    logic                        r_sat;
    logic [bvcp_pkg::OHM_W-1:0]  r_rem;
    logic [bvcp_pkg::PACK_W-1:0] r_dq;
    logic [bvcp_pkg::OHM_W-1:0]  r_dvs;
    logic [bvcp_pkg::CNT_W-1:0]  r_cnt;
    logic [bvcp_pkg::CELL_W-1:0] r_cell;
    logic [bvcp_pkg::SEG_W-1:0]  r_seg;
    logic [bvcp_pkg::PCT_W-1:0]  r_pct;

    // Stored pack state
    logic [bvcp_pkg::PACK_W-1:0] r_pack;
    logic                        r_have;

    logic [bvcp_pkg::OHM_W:0]    w_trial;
    logic                        w_ge;
    logic                        w_sat;
    logic [CPROD_W-1:0]          w_cell_prod;
    logic                        w_lo_clamp;
    logic                        w_hi_clamp;
    logic [bvcp_pkg::SEG_W-1:0]  w_seg;
    logic [bvcp_pkg::CELL_W-1:0] w_lo_mv;
    logic [bvcp_pkg::CELL_W-1:0] w_hi_mv;
    logic [bvcp_pkg::CELL_W-1:0] w_diff;
    logic [bvcp_pkg::PIN_W-1:0]  w_num;

    // Restoring division step: shift in one dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dq[bvcp_pkg::PACK_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // Quotient above 16 bits when the upper product bits reach the divisor
    assign w_sat = ({4'd0, r_prod[bvcp_pkg::PROD_W-1:bvcp_pkg::PACK_W]} >= i_out_ohms);

    // Per-cell voltage of the stored pack
    assign w_cell_prod = CPROD_W'(r_pack) * CPROD_W'(CELL_RECIP);

    // Locate the curve segment of the per-cell quotient
    always_comb begin
        w_lo_clamp = ({1'b0, r_dq} <= {4'd0, bvcp_pkg::ocv_point(4'd0)});
        w_hi_clamp = ({1'b0, r_dq} >= {4'd0, bvcp_pkg::ocv_point(bvcp_pkg::OCV_LAST)});
        w_seg      = '0;
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, r_dq} > {4'd0, bvcp_pkg::ocv_point(4'(k))}) begin
                w_seg = w_seg + 4'd1;
            end
        end
    end

    // Interpolation numerator and segment width
    assign w_lo_mv = bvcp_pkg::ocv_point(r_seg);
    assign w_hi_mv = bvcp_pkg::ocv_point(r_seg + 4'd1);
    assign w_diff  = r_cell - w_lo_mv;
    assign w_num   = 12'(w_diff[7:0]) * 12'(bvcp_pkg::PCT_STEP);

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pin <= i_pin_millivolts;
            r_ok  <= i_sample_ok;
        end
    end

    // Execute the current micro-operation
    always_ff @(posedge i_clk) begin
        case (i_op)
            bvcp_pkg::OP_MUL: begin
                r_prod <= bvcp_pkg::PROD_W'(r_pin) * bvcp_pkg::PROD_W'(i_full_ohms);
            end
            bvcp_pkg::OP_LD_SCALE: begin
                r_sat <= w_sat;
                r_rem <= {4'd0, r_prod[bvcp_pkg::PROD_W-1:bvcp_pkg::PACK_W]};
                r_dq  <= r_prod[bvcp_pkg::PACK_W-1:0];
                r_dvs <= i_out_ohms;
                r_cnt <= bvcp_pkg::DIV_BITS;
            end
            bvcp_pkg::OP_DIV_STEP: begin
                r_rem <= w_ge ? bvcp_pkg::OHM_W'(w_trial - {1'b0, r_dvs})
                              : w_trial[bvcp_pkg::OHM_W-1:0];
                r_dq  <= {r_dq[bvcp_pkg::PACK_W-2:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
            end
            bvcp_pkg::OP_LD_CELL: begin
                r_dq  <= w_cell_prod[RECIP_SHIFT +: bvcp_pkg::PACK_W];
                r_pct <= '0;
            end
            bvcp_pkg::OP_SEG: begin
                r_cell <= r_dq[bvcp_pkg::CELL_W-1:0];
                r_seg  <= w_seg;
                r_pct  <= (w_hi_clamp && !w_lo_clamp) ? bvcp_pkg::PCT_FULL : '0;
            end
            bvcp_pkg::OP_LD_FRAC: begin
                r_rem <= '0;
                r_dq  <= bvcp_pkg::PACK_W'(w_num);
                r_dvs <= bvcp_pkg::OHM_W'(w_hi_mv - w_lo_mv);
                r_cnt <= bvcp_pkg::DIV_BITS;
            end
            bvcp_pkg::OP_SET_PCT: begin
                r_pct <= bvcp_pkg::PCT_W'(r_seg) * bvcp_pkg::PCT_STEP
                         + {3'd0, r_dq[3:0]};
            end
            default: begin
            end
        endcase
    end

    // Hold the stored pack voltage and the reading flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack <= '0;
            r_have <= 1'b0;
        end else if (i_op == bvcp_pkg::OP_STORE_PACK) begin
            r_pack <= r_sat ? bvcp_pkg::PACK_MAX : r_dq;
            r_have <= 1'b1;
        end
    end

    assign o_stat.sample_ok    = r_ok;
    assign o_stat.have_reading = r_have;
    assign o_stat.cnt_last     = (r_cnt == 5'd1);
    assign o_stat.clamp        = w_lo_clamp || w_hi_clamp;

    assign o_pack_millivolts = r_pack;
    assign o_charge_percent  = r_pct;
    assign o_reading_present = r_have;

endmodule

[rtl/battery_voltage_to_charge_percent_unit.sv]
// ----------------------------------------------------------------------------
// battery_voltage_to_charge_percent_unit: pack voltage and charge estimator
// Scales an ADC pin reading by the divider ratio, keeps the pack voltage and
// interpolates the per-cell charge percent on a LiPo rest-voltage curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one pin reading in mV and
//   a success flag. A failed sample leaves the stored pack voltage alone.
//   Output channel (o_out_valid / i_out_stall) returns one transaction per
//   input: stored pack mV, charge percent (0..100) and a reading-present flag.
//   Configuration: i_cfg_we with i_cfg_index 0 writes the total divider
//   resistance, index 1 the tap leg resistance; write only while idle.
// Timing:
//   A microcoded sequencer runs one step per cycle; two 16-step passes of the
//   shared restoring divider (divider ratio, interpolation) dominate. A
//   successful sample runs multiply, ratio pass, store, cell voltage, segment
//   search, interpolation pass and percent, then loads the output register; a
//   clamped cell voltage skips interpolation and percent, a failed sample the
//   ratio pass and store, no reading yet all after the cell voltage. One more
//   step returns to idle; o_in_stall is high while busy.
// Reset:
//   Both divider registers return to 1, the stored voltage to 0, no reading.
// Back-pressure:
//   A finished result waits in the publish step while the output register is
//   full and stalled; the output payload holds.
// ----------------------------------------------------------------------------
module battery_voltage_to_charge_percent_unit #(
    parameter int CELL_COUNT = bvcp_pkg::CELL_COUNT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bvcp_pkg::PIN_W-1:0]           i_pin_millivolts,
    input  logic                                 i_sample_ok,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bvcp_pkg::PACK_W-1:0]          o_pack_millivolts,
    output logic [bvcp_pkg::PCT_W-1:0]           o_charge_percent,
    output logic                                 o_reading_present,
    input  logic                                 i_cfg_we,
    input  logic [bvcp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bvcp_pkg::OHM_W-1:0]           i_cfg_data
);

    logic [bvcp_pkg::OHM_W-1:0]  r_full_ohms;
    logic [bvcp_pkg::OHM_W-1:0]  r_out_ohms;
    logic                        r_out_valid;
    logic [bvcp_pkg::PACK_W-1:0] r_out_pack;
    logic [bvcp_pkg::PCT_W-1:0]  r_out_pct;
    logic                        r_out_have;

    bvcp_pkg::t_op               w_op;
    bvcp_pkg::t_dp_stat          w_stat;
    logic                        w_idle;
    logic                        w_accept;
    logic                        w_out_busy;
    logic                        w_publish;
    logic [bvcp_pkg::PACK_W-1:0] w_pack;
    logic [bvcp_pkg::PCT_W-1:0]  w_pct;
    logic                        w_have;

    assign o_in_stall = !w_idle;
    assign w_accept   = i_in_valid && w_idle;
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_publish  = (w_op == bvcp_pkg::OP_PUBLISH) && !w_out_busy;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_ohms <= 24'd1;
            r_out_ohms  <= 24'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bvcp_pkg::REG_FULL_OHMS: r_full_ohms <= i_cfg_data;
                bvcp_pkg::REG_OUT_OHMS:  r_out_ohms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bvcp_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid),
        .i_out_busy (w_out_busy),
        .i_stat     (w_stat),
        .o_op       (w_op),
        .o_idle     (w_idle)
    );

    bvcp_dpath #(
        .CELL_COUNT (CELL_COUNT)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_accept),
        .i_pin_millivolts  (i_pin_millivolts),
        .i_sample_ok       (i_sample_ok),
        .i_full_ohms       (r_full_ohms),
        .i_out_ohms        (r_out_ohms),
        .i_op              (w_op),
        .o_stat            (w_stat),
        .o_pack_millivolts (w_pack),
        .o_charge_percent  (w_pct),
        .o_reading_present (w_have)
    );

    // Track output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result transaction
    always_ff @(posedge i_clk) begin
        if (w_publish) begin
            r_out_pack <= w_pack;
            r_out_pct  <= w_pct;
            r_out_have <= w_have;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pack_millivolts = r_out_pack;
    assign o_charge_percent  = r_out_pct;
    assign o_reading_present = r_out_have;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the battery charge percent unit
// Drives ADC pin readings through the valid/stall input channel and predicts
// the stored pack voltage, the interpolated per-cell charge percent and the
// reading-present flag for every transaction. Each result is checked against
// the oldest prediction. The run covers several divider settings, including
// zero and full-scale resistances, under random idling on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_PCT      = 15;
    localparam int RAND_PHASES   = 20;
    localparam int PHASE_ITEMS   = 100;
    localparam int QUIET_PHASE   = 3;
    localparam int HOLD_TRIGGER  = 600;
    localparam int HOLD_CYCLES   = 500;
    localparam int WATCHDOG      = 4000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [bvcp_pkg::PIN_W-1:0] pin_mv;
        logic                       ok;
    } t_sample;

    typedef struct packed {
        logic [bvcp_pkg::PACK_W-1:0] pack_mv;
        logic [bvcp_pkg::PCT_W-1:0]  pct;
        logic                        present;
    } t_charge;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_vld = 1'b0;
    logic                           in_stall;
    logic [bvcp_pkg::PIN_W-1:0]     pin_mv = '0;
    logic                           sample_ok = 1'b0;
    logic                           out_vld;
    logic                           out_stall = 1'b0;
    logic [bvcp_pkg::PACK_W-1:0]    pack_mv;
    logic [bvcp_pkg::PCT_W-1:0]     charge_pct;
    logic                           reading_present;
    logic                           cfg_we = 1'b0;
    logic [bvcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bvcp_pkg::OHM_W-1:0]     cfg_data = '0;

    // Rest voltage of one cell at 0%, 10%, ... 100%
    int rest_mv [11] = '{3450, 3680, 3740, 3770, 3790, 3820, 3870, 3920, 3980, 4060, 4200};

    // Predictor state: divider setting and stored reading
    logic [bvcp_pkg::OHM_W-1:0]  full_ohms_q = 24'd1;
    logic [bvcp_pkg::OHM_W-1:0]  tap_ohms_q = 24'd1;
    logic [bvcp_pkg::PACK_W-1:0] stored_pack_q = '0;
    logic                        have_reading_q = 1'b0;

    t_sample pending_samples[$];
    t_charge expected_charge[$];

    bit quiet = 1'b0;
    int err_cnt = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int saturated_cnt = 0;
    int interp_cnt = 0;
    int full_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stuck_cycles = 0;

    battery_voltage_to_charge_percent_unit DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_vld),
        .o_in_stall        (in_stall),
        .i_pin_millivolts  (pin_mv),
        .i_sample_ok       (sample_ok),
        .o_out_valid       (out_vld),
        .i_out_stall       (out_stall),
        .o_pack_millivolts (pack_mv),
        .o_charge_percent  (charge_pct),
        .o_reading_present (reading_present),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // Percent of charge for one cell voltage, linear between curve points
    function automatic logic [bvcp_pkg::PCT_W-1:0] cell_soc(input int cell_mv);
        int k;
        int pct;
        pct = 100;
        if (cell_mv <= rest_mv[0]) begin
            pct = 0;
        end else begin
            for (k = 10; k >= 1; k--) begin
                if (cell_mv <= rest_mv[k]) begin
                    pct = (k - 1) * 10
                        + ((cell_mv - rest_mv[k-1]) * 10) / (rest_mv[k] - rest_mv[k-1]);
                end
            end
        end
        return pct[bvcp_pkg::PCT_W-1:0];
    endfunction

    // Update the stored reading and queue the charge report it produces
    function automatic void predict_charge(input t_sample s);
        longint unsigned scaled;
        t_charge r;
        if (s.ok) begin
            if (tap_ohms_q == '0) begin
                stored_pack_q = bvcp_pkg::PACK_MAX;
            end else begin
                scaled = (longint'(s.pin_mv) * longint'(full_ohms_q))
                         / longint'(tap_ohms_q);
                stored_pack_q = (scaled > 65535) ? bvcp_pkg::PACK_MAX
                                                 : scaled[bvcp_pkg::PACK_W-1:0];
            end
            have_reading_q = 1'b1;
        end
        r.pack_mv = stored_pack_q;
        r.present = have_reading_q;
        r.pct = have_reading_q ? cell_soc(int'(stored_pack_q) / bvcp_pkg::CELL_COUNT) : '0;
        if (r.pack_mv == bvcp_pkg::PACK_MAX) saturated_cnt++;
        if (r.pct == bvcp_pkg::PCT_FULL) full_cnt++;
        else if (r.pct != '0) interp_cnt++;
        expected_charge.push_back(r);
    endfunction

    // Driver: present queued samples, hold while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_vld <= 1'b0;
        end else begin
            if (in_vld && !in_stall) begin
                predict_charge('{pin_mv: pin_mv, ok: sample_ok});
                samples_sent++;
            end
            if (in_vld && in_stall) begin
                in_vld <= 1'b1;
            end else if (pending_samples.size() != 0
                         && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_vld    <= 1'b1;
                pin_mv    <= pending_samples[0].pin_mv;
                sample_ok <= pending_samples[0].ok;
                void'(pending_samples.pop_front());
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // Monitor: check each output transaction, drive back-pressure
    always @(posedge clk) begin
        t_charge exp_r;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_vld && !out_stall) begin
                results_seen++;
                if (expected_charge.size() == 0) begin
                    err_cnt++;
                    $display("%0t unexpected result: pack %0d pct %0d present %0d",
                             $time, pack_mv, charge_pct, reading_present);
                end else begin
                    exp_r = expected_charge.pop_front();
                    if (pack_mv !== exp_r.pack_mv) begin
                        err_cnt++;
                        $display("%0t pack_millivolts mismatch: expected %0d actual %0d",
                                 $time, exp_r.pack_mv, pack_mv);
                    end
                    if (charge_pct !== exp_r.pct) begin
                        err_cnt++;
                        $display("%0t charge_percent mismatch: expected %0d actual %0d",
                                 $time, exp_r.pct, charge_pct);
                    end
                    if (reading_present !== exp_r.present) begin
                        err_cnt++;
                        $display("%0t reading_present mismatch: expected %0d actual %0d",
                                 $time, exp_r.present, reading_present);
                    end
                end
            end
            // hold off once for a long stretch so the unit backs up
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Count cycles without any accepted transaction
    always @(posedge clk) begin
        if (!rst_n || (in_vld && !in_stall) || (out_vld && !out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        while (stuck_cycles < WATCHDOG) @(posedge clk);
        $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG);
        $display("tb_top: errors");
        $finish;
    end

    task automatic queue_sample(input int pin, input bit ok);
        t_sample s;
        s.pin_mv = pin[bvcp_pkg::PIN_W-1:0];
        s.ok = ok;
        pending_samples.push_back(s);
    endtask

    // Write one divider register and mirror it in the predictor
    task automatic write_divider(input logic [bvcp_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [bvcp_pkg::OHM_W-1:0] ohms);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ohms;
        if (idx == bvcp_pkg::REG_FULL_OHMS) full_ohms_q = ohms;
        else tap_ohms_q = ohms;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_divider(input logic [bvcp_pkg::OHM_W-1:0] full,
                               input logic [bvcp_pkg::OHM_W-1:0] tap);
        write_divider(bvcp_pkg::REG_FULL_OHMS, full);
        write_divider(bvcp_pkg::REG_OUT_OHMS, tap);
    endtask

    // Wait until every queued sample has been reported
    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_vld || expected_charge.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int k;
        int p;
        int n;
        int pin;
        int roll;
        longint unsigned target;
        logic [bvcp_pkg::OHM_W-1:0] full;
        logic [bvcp_pkg::OHM_W-1:0] tap;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset divider: no reading yet, then plain pass-through
        queue_sample(4095, 1'b0);
        queue_sample(0, 1'b1);
        queue_sample(4095, 1'b1);
        queue_sample(1234, 1'b0);
        wait_drained();

        // Ratio 3 on a two-cell pack: hit each curve point and both clamps
        set_divider(24'd3, 24'd1);
        for (k = 0; k < 11; k++) queue_sample((2 * rest_mv[k] + 2) / 3, 1'b1);
        queue_sample(2301, 1'b1);
        queue_sample(2799, 1'b1);
        queue_sample(0, 1'b0);
        wait_drained();

        // Huge ratio: saturation of the pack voltage
        set_divider(24'hFFFFFF, 24'd1);
        queue_sample(1, 1'b1);
        queue_sample(4095, 1'b1);
        wait_drained();

        // Zero total resistance stores zero
        set_divider(24'd0, 24'hFFFFFF);
        queue_sample(4095, 1'b1);
        wait_drained();

        // Zero tap resistance counts as unbounded ratio
        set_divider(24'hFFFFFF, 24'd0);
        queue_sample(1, 1'b1);
        wait_drained();

        // Random divider settings, readings mostly aimed at the curve
        for (p = 0; p < RAND_PHASES; p++) begin
            if ($urandom_range(0, 3) != 0) begin
                tap  = 24'($urandom_range(1, 1000000));
                full = 24'((longint'(tap) * $urandom_range(17, 40)) / 10);
            end else begin
                tap  = 24'($urandom_range(1, 24'hFFFFFF));
                full = 24'($urandom_range(0, 24'hFFFFFF));
            end
            set_divider(full, tap);
            quiet = (p == QUIET_PHASE);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                pin = $urandom_range(0, 4095);
                if (roll < 70 && full != '0) begin
                    target = (longint'($urandom_range(6700, 8600)) * longint'(tap)) / full;
                    if (target <= 4095) pin = int'(target);
                end else if (roll >= 90) begin
                    pin = ($urandom_range(0, 1) != 0) ? 4095 : 0;
                end
                queue_sample(pin, $urandom_range(0, 99) >= 15);
            end
            wait_drained();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d samples and %0d reports over %0d divider settings",
                 samples_sent, results_seen, RAND_PHASES + 5);
        $display("reports: %0d saturated pack, %0d interpolated, %0d at full charge",
                 saturated_cnt, interp_cnt, full_cnt);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
